FILE: hdl/fltw_pkg.sv
// Shared types and constants of the fused-lasso tridiagonal weight unit.
// No dependencies; imported by all modules of the unit.
package fltw_pkg;

  localparam int COEF_W      = 32;
  localparam int GC_W        = 16;
  localparam int REG_W       = 32;
  localparam int REG_ADDR_W  = 2;
  localparam int IDX_W       = 12;
  localparam int VAL_W       = 48;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 112;
  localparam int OUT_USER_W  = 2;

  localparam int MAX_LENGTH  = 4096;
  localparam int POS_W       = $clog2(MAX_LENGTH);

  localparam int FRAC_W      = 16;
  localparam int NUM_W       = 48;
  localparam int DEN_W       = 33;
  localparam int DIV_STEPS   = 48;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int SUM_W       = 50;

  localparam logic [VAL_W-1:0] POS_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] SIDE_CAP = 48'h8000_0000_0000;
  localparam logic [REG_W-1:0] EPS_RESET = 32'd1;

  localparam logic [REG_ADDR_W-1:0] REG_L1_WEIGHT     = 2'd0;
  localparam logic [REG_ADDR_W-1:0] REG_FUSION_WEIGHT = 2'd1;
  localparam logic [REG_ADDR_W-1:0] REG_DENOM_EPS     = 2'd2;

  typedef enum logic [1:0] {
    OP_SIDE        = 2'd0,
    OP_LASSO_PRIOR = 2'd1,
    OP_LASSO_CUR   = 2'd2
  } op_t;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic div_start;
    logic store;
    logic emit_pair;
    logic emit_last;
    logic commit;
    logic clear;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic have_prior;
    logic cur_fin;
    logic out_free;
    logic div_busy;
  } stat_t;

endpackage

FILE: hdl/fltw_div.sv
// Radix-2 restoring divider computing (num * 2^16) / den, one quotient bit per cycle.
// Depends on fltw_pkg.
module fltw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fltw_pkg::NUM_W-1:0]     num,
  input  logic [fltw_pkg::DEN_W-1:0]     den,
  output logic                          busy,
  output logic [fltw_pkg::DIV_STEPS-1:0] quo,
  output logic                          ovf
);
  import fltw_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den_q;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DEN_W+1:0]     trial;
  logic [DEN_W-1:0]     hi_part;

  // quotient bits at 2^48 and above only show up as overflow
  assign hi_part = DEN_W'(num[NUM_W-1 -: FRAC_W]);
  assign trial   = {1'b0, rem, quo[DIV_STEPS-1]} - {2'b00, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= hi_part;
      den_q <= den;
      ovf   <= (hi_part >= den);
      quo   <= {num[NUM_W-FRAC_W-1:0], FRAC_W'(0)};
    end else if (busy) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-2:0], quo[DIV_STEPS-1]};
        quo <= {quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: hdl/fltw_dp.sv
// Datapath: config registers, stream state, operand setup, divider, saturation, output register.
// Depends on fltw_pkg and fltw_div.
module fltw_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  fltw_pkg::cmd_t                  cmd,
  output fltw_pkg::stat_t                 stat,
  input  logic [fltw_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fltw_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [fltw_pkg::OUT_USER_W-1:0] m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [fltw_pkg::REG_ADDR_W-1:0] cfg_addr,
  input  logic [fltw_pkg::REG_W-1:0]      cfg_data
);
  import fltw_pkg::*;

  logic [REG_W-1:0]  l1_weight;
  logic [REG_W-1:0]  fusion_weight;
  logic [REG_W-1:0]  denominator_epsilon;
  logic [REG_W-1:0]  eps_eff;

  logic [COEF_W-1:0] cur_coef;
  logic [GC_W-1:0]   cur_gc;
  logic              cur_fin;
  logic [COEF_W-1:0] prior_coef;
  logic [GC_W-1:0]   prior_gc;
  logic [VAL_W-1:0]  prior_sm;
  logic              have_prior;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;

  logic [GC_W-1:0]   gc_sel;
  logic [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]  num_next;
  logic [DEN_W-1:0]  x_ext;
  logic [DEN_W-1:0]  y_ext;
  logic [DEN_W-1:0]  diff;
  logic [DEN_W-1:0]  mag;
  logic [NUM_W-1:0]  num_reg;
  logic [DEN_W-1:0]  mag_reg;
  logic [DEN_W-1:0]  den;

  logic                 div_busy;
  logic [DIV_STEPS-1:0] quo;
  logic                 div_ovf;
  logic                 side_sat;
  logic                 lasso_sat;

  logic [VAL_W-1:0]  sm;
  logic              sm_clip;
  logic [VAL_W-1:0]  a_val;
  logic              a_clip;

  logic [VAL_W-1:0]  s1;
  logic [VAL_W-1:0]  s2;
  logic [SUM_W-1:0]  sum;
  logic              sum_sat;
  logic [VAL_W-1:0]  main_val;

  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [VAL_W-1:0]  out_main;
  logic [VAL_W-1:0]  out_side;
  logic              out_sv;
  logic              out_clip;
  logic              out_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      l1_weight           <= '0;
      fusion_weight       <= '0;
      denominator_epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_L1_WEIGHT:     l1_weight           <= cfg_data;
        REG_FUSION_WEIGHT: fusion_weight       <= cfg_data;
        REG_DENOM_EPS:     denominator_epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eps_eff = (denominator_epsilon == '0) ? REG_W'(1) : denominator_epsilon;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_coef <= s_tdata[COEF_W-1:0];
      cur_gc   <= s_tdata[COEF_W +: GC_W];
      cur_fin  <= s_tlast;
    end
  end

  assign pos_next = (pos == POS_W'(MAX_LENGTH - 1)) ? '0 : pos + POS_W'(1);

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prior <= 1'b0;
      pos        <= '0;
      prior_coef <= '0;
      prior_gc   <= '0;
      prior_sm   <= '0;
    end else if (cmd.clear) begin
      have_prior <= 1'b0;
      pos        <= '0;
      prior_coef <= '0;
      prior_gc   <= '0;
      prior_sm   <= '0;
    end else if (cmd.commit) begin
      have_prior <= 1'b1;
      prior_coef <= cur_coef;
      prior_gc   <= cur_gc;
      prior_sm   <= have_prior ? sm : '0;
      pos        <= have_prior ? pos_next : pos;
    end
  end

  // operand setup
  always_comb begin
    gc_sel   = (cmd.op == OP_LASSO_PRIOR) ? prior_gc : cur_gc;
    prod     = NUM_W'(gc_sel) * NUM_W'(l1_weight);
    num_next = (cmd.op == OP_SIDE) ? NUM_W'(fusion_weight) : prod;
    x_ext    = (cmd.op == OP_LASSO_PRIOR) ? {prior_coef[COEF_W-1], prior_coef}
                                          : {cur_coef[COEF_W-1], cur_coef};
    y_ext    = (cmd.op == OP_SIDE) ? {prior_coef[COEF_W-1], prior_coef} : '0;
    diff     = x_ext - y_ext;
    mag      = diff[DEN_W-1] ? (~diff + DEN_W'(1)) : diff;
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      num_reg <= num_next;
      mag_reg <= mag;
    end
  end

  assign den = mag_reg + DEN_W'(eps_eff);

  fltw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_reg),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo),
    .ovf   (div_ovf)
  );

  // saturation of quotients
  assign side_sat  = div_ovf | (quo[VAL_W-1] & (|quo[VAL_W-2:0]));
  assign lasso_sat = div_ovf | quo[VAL_W-1];

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (cmd.op == OP_SIDE) begin
        sm      <= side_sat ? SIDE_CAP : quo;
        sm_clip <= side_sat;
      end else begin
        a_val  <= lasso_sat ? POS_MAX : quo;
        a_clip <= lasso_sat;
      end
    end
  end

  // main diagonal sum
  always_comb begin
    s1       = have_prior ? sm : '0;
    s2       = cmd.emit_pair ? prior_sm : '0;
    sum      = SUM_W'(a_val) + SUM_W'(s1) + SUM_W'(s2);
    sum_sat  = |sum[SUM_W-1:VAL_W-1];
    main_val = sum_sat ? POS_MAX : sum[VAL_W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_pair || cmd.emit_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pair) begin
      out_index <= IDX_W'(pos);
      out_main  <= main_val;
      out_side  <= '0 - sm;
      out_sv    <= 1'b1;
      out_clip  <= sm_clip | a_clip | sum_sat;
      out_last  <= 1'b0;
    end else if (cmd.emit_last) begin
      out_index <= have_prior ? IDX_W'(pos_next) : IDX_W'(pos);
      out_main  <= main_val;
      out_side  <= '0;
      out_sv    <= 1'b0;
      out_clip  <= a_clip | sum_sat;
      out_last  <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W - IDX_W - 2 * VAL_W)'(0), out_side, out_main, out_index};
  assign m_tuser  = {out_clip, out_sv};
  assign m_tlast  = out_last;

  assign stat.have_prior = have_prior;
  assign stat.cur_fin    = cur_fin;
  assign stat.out_free   = !out_valid || m_tready;
  assign stat.div_busy   = div_busy;

endmodule

FILE: hdl/fltw_ctrl.sv
// Controller: sequences the divisions and result transfers of one element.
// Depends on fltw_pkg.
module fltw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  fltw_pkg::stat_t stat,
  output fltw_pkg::cmd_t  cmd
);
  import fltw_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECIDE    = 8'b0000_0010,
    S_SETUP     = 8'b0000_0100,
    S_START     = 8'b0000_1000,
    S_WAIT      = 8'b0001_0000,
    S_STORE     = 8'b0010_0000,
    S_EMIT_PAIR = 8'b0100_0000,
    S_EMIT_LAST = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  op_t    op;
  op_t    op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_SIDE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.have_prior && !stat.cur_fin) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end else if (!stat.have_prior) begin
          op_next    = OP_LASSO_CUR;
          state_next = S_SETUP;
        end else begin
          op_next    = OP_SIDE;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        unique case (op)
          OP_SIDE: begin
            op_next    = OP_LASSO_PRIOR;
            state_next = S_SETUP;
          end
          OP_LASSO_PRIOR: state_next = S_EMIT_PAIR;
          default:        state_next = S_EMIT_LAST;
        endcase
      end
      S_EMIT_PAIR: begin
        if (stat.out_free) begin
          cmd.emit_pair = 1'b1;
          if (stat.cur_fin) begin
            op_next    = OP_LASSO_CUR;
            state_next = S_SETUP;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_LAST: begin
        if (stat.out_free) begin
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/fused_lasso_tridiagonal_weights_unit.sv
// Fused-lasso tridiagonal weight unit, top level.
// Depends on fltw_pkg, fltw_ctrl and fltw_dp.
//
// Coefficients arrive on the s_ channel one element per transfer, tlast on the last
// element of a vector. Entry k of the tridiagonal weight matrix leaves on the m_
// channel once element k+1 has arrived; the last element also sends its own entry.
// The three weights are written through cfg_we/cfg_addr/cfg_data; the user must do so
// only while the unit is idle, which the block itself does not enforce. Each division
// runs on one shared restoring divider, one quotient bit per cycle. An element that
// only opens a vector needs no division; an element with a predecessor takes two
// divisions, and a last element with a predecessor three. The next element is taken
// once the current one is finished.
// Results sit in an output register; a stalled receiver holds the controller before
// the next result only, so the first result of an element may wait while work goes on.
// Reset clears the stream state and the output register and loads the weight
// registers with their defaults (epsilon 1, both penalties 0).
module fused_lasso_tridiagonal_weights_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fltw_pkg::IN_DATA_W-1:0]  s_tdata,   // coefficient, group_count
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fltw_pkg::OUT_DATA_W-1:0] m_tdata,   // entry_index, main_value, side_value
  output logic [fltw_pkg::OUT_USER_W-1:0] m_tuser,   // side_valid, clipped
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [fltw_pkg::REG_ADDR_W-1:0] cfg_addr,
  input  logic [fltw_pkg::REG_W-1:0]      cfg_data
);
  import fltw_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fltw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fltw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  a_idle_no_div: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.div_busy)
    else $error("input ready while divider busy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pair || cmd.emit_last) |-> stat.out_free)
    else $error("result written over a pending transfer");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

  a_emit_last_tlast: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_last |=> (m_tvalid && m_tlast && !m_tuser[0]))
    else $error("final entry not marked");

endmodule
